/* rtl/pmtf_pkg.sv */
// Shared types and constants of the partial move-to-front coder.
// Used by pmtf_div and partial_move_to_front_coder_top; depends on nothing.
package pmtf_pkg;

   // Width of the move divisor register and of the divider's divisor input.
   localparam int DIVISOR_W = 8;
   // Width of the input value and output value fields.
   localparam int VALUE_W   = 7;
   // Reset value of the move divisor register.
   localparam logic [DIVISOR_W-1:0] DIVISOR_RESET = 8'd2;

   // Status of the shared divider, as seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

/* rtl/pmtf_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on pmtf_pkg for the divisor width and the status struct.
module pmtf_div import pmtf_pkg::*; #(
   parameter int QW = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [QW-1:0]        dividend,
   input  logic [DIVISOR_W-1:0] divisor,
   output logic [QW-1:0]        quotient,
   output div_stat_type         stat
);

   localparam int CW = $clog2(QW + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dsr_ff, dsr_in;
   logic [QW-1:0]        quo_ff, quo_in;
   logic [DIVISOR_W:0]   trial;
   logic [DIVISOR_W:0]   diff;
   logic                 ge;

   // The dividend shifts out at the top while quotient bits shift in below.
   assign trial = {rem_ff, quo_ff[QW-1]};
   assign ge    = trial >= {1'b0, dsr_ff};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(QW - 1);
         rem_in  = '0;
         dsr_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in = (quo_ff << 1) | QW'(ge);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

/* rtl/partial_move_to_front_coder_top.sv */
// Top level of the partial move-to-front coder: sequencer, symbol list memory
// and configuration register. Depends on pmtf_pkg and pmtf_div.
//
// The block keeps a list of ALPHABET_SIZE symbols, in identity order after
// reset. A request transaction carries op, in_value and restart. With op 0
// the symbol in_value is searched in the list and its position is returned;
// with op 1 the symbol stored at position in_value is returned. In both cases
// the entry found at position s then moves to position s / move_divisor and
// the entries in between shift one place toward the end. A divisor of 0 or 1
// leaves the list alone. A set restart flag returns the list to identity
// order before the transaction is worked on. Every request produces exactly
// one response transaction. The list sits in a memory with one registered
// read and one write per cycle, so the search and the shift walk it one entry
// per cycle. An encode searches the list from the front and a decode reads
// the entry at in_value; a move then runs the divider, shifts the entries at
// e to s - 1 one place toward the end and stores the found symbol at e, where
// e is the quotient. req_ready is high only while the block is idle, so a new
// request is taken only once the last result has left the sequencer. The
// response waits in an output register; while the receiver stalls it, the next
// result waits in the sequencer. Reset restores identity order and divisor 2.
module partial_move_to_front_coder_top import pmtf_pkg::*; #(
   parameter int ALPHABET_SIZE = 128
) (
   input  logic               clock,
   input  logic               reset,
   // Request channel.
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic [VALUE_W-1:0] req_in_value,
   input  logic               req_restart,
   // Response channel.
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [VALUE_W-1:0] rsp_out_value,
   // Configuration port.
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int IW = $clog2(ALPHABET_SIZE);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SEARCH = 3'd1;
   localparam logic [2:0] S_DREAD  = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_MOVE   = 3'd4;
   localparam logic [2:0] S_LAST   = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0]           state_ff, state_in;
   logic [DIVISOR_W-1:0] divisor_ff, divisor_in;
   logic [VALUE_W-1:0]   value_ff, value_in;
   logic [IW-1:0]        pos_ff, pos_in;
   logic [IW-1:0]        s_ff, s_in;
   logic [IW-1:0]        e_ff, e_in;
   logic [IW-1:0]        sym_ff, sym_in;
   logic [VALUE_W-1:0]   res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]   rsp_data_ff, rsp_data_in;

   // Symbol list memory with registered read data. An entry whose valid bit
   // is clear has not been written since reset or restart and reads as its
   // own index.
   logic [IW-1:0]            list_mem [ALPHABET_SIZE];
   logic [ALPHABET_SIZE-1:0] valid_ff;
   logic [IW-1:0]            rdata_ff;
   logic                     rvalid_ff;
   logic [IW-1:0]            ridx_ff;
   logic [IW-1:0]            raddr;
   logic                     we;
   logic [IW-1:0]            waddr;
   logic [IW-1:0]            wdata;
   logic                     clear;
   logic [IW-1:0]            entry;
   logic [8:0]               entry_w;
   logic [8:0]               pos_w;

   logic                 div_start;
   logic [IW-1:0]        div_dividend;
   logic [IW-1:0]        div_quot;
   div_stat_type         div_stat;
   logic                 no_move;
   logic                 req_acc;
   logic                 cfg_wr;

   assign entry   = rvalid_ff ? rdata_ff : ridx_ff;
   assign entry_w = 9'(entry);
   assign pos_w   = 9'(pos_ff);
   assign req_acc = req_valid && req_ready;
   assign no_move = divisor_ff <= DIVISOR_W'(1);

   assign req_ready     = state_ff == S_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rsp_data_ff;

   // Configuration: one register, selected while paddr[2] is low (byte addresses 0 to 3); addresses 4 to 7 read 0.
   assign pready     = 1'b1;
   assign cfg_wr     = psel && penable && pwrite && pready;
   assign divisor_in = (cfg_wr && !paddr[2]) ? pwdata[DIVISOR_W-1:0] : divisor_ff;
   assign prdata     = paddr[2] ? 32'd0 : 32'(divisor_ff);

   pmtf_div #(
      .QW(IW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (divisor_ff),
      .quotient (div_quot),
      .stat     (div_stat)
   );

   // Sequencer. The search and the shift are pipelined against the memory:
   // the read for the next position is issued while the current one is used.
   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      pos_in       = pos_ff;
      s_in         = s_ff;
      e_in         = e_ff;
      sym_in       = sym_ff;
      res_in       = res_ff;
      raddr        = '0;
      we           = 1'b0;
      waddr        = pos_ff;
      wdata        = entry;
      clear        = 1'b0;
      div_start    = 1'b0;
      div_dividend = s_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               value_in = req_in_value;
               clear    = req_restart;
               if (!req_op) begin
                  raddr    = '0;
                  pos_in   = '0;
                  state_in = S_SEARCH;
               end else if (9'(req_in_value) < 9'(ALPHABET_SIZE)) begin
                  raddr    = IW'(req_in_value);
                  s_in     = IW'(req_in_value);
                  state_in = S_DREAD;
               end else begin
                  res_in   = '0;
                  state_in = S_DONE;
               end
            end
         end
         S_SEARCH: begin
            if (entry_w == 9'(value_ff)) begin
               res_in       = pos_w[VALUE_W-1:0];
               s_in         = pos_ff;
               sym_in       = entry;
               div_dividend = pos_ff;
               if (no_move || pos_ff == '0) begin
                  state_in = S_DONE;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
            end else if (pos_ff == IW'(ALPHABET_SIZE - 1)) begin
               res_in   = '0;
               state_in = S_DONE;
            end else begin
               raddr  = pos_ff + IW'(1);
               pos_in = pos_ff + IW'(1);
            end
         end
         S_DREAD: begin
            res_in       = entry_w[VALUE_W-1:0];
            sym_in       = entry;
            div_dividend = s_ff;
            if (no_move || s_ff == '0) begin
               state_in = S_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               e_in     = div_quot;
               raddr    = s_ff - IW'(1);
               pos_in   = s_ff;
               state_in = S_MOVE;
            end
         end
         S_MOVE: begin
            // The entry one place nearer the front shifts into this slot.
            we    = 1'b1;
            waddr = pos_ff;
            wdata = entry;
            if (pos_ff - IW'(1) == e_ff) begin
               state_in = S_LAST;
            end else begin
               raddr  = pos_ff - IW'(2);
               pos_in = pos_ff - IW'(1);
            end
         end
         S_LAST: begin
            we       = 1'b1;
            waddr    = e_ff;
            wdata    = sym_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         divisor_ff   <= DIVISOR_RESET;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         divisor_ff   <= divisor_in;
         rsp_valid_ff <= rsp_valid_in;
         if (clear) begin
            valid_ff <= '0;
         end else if (we) begin
            valid_ff[waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      pos_ff      <= pos_in;
      s_ff        <= s_in;
      e_ff        <= e_in;
      sym_ff      <= sym_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (we) begin
         list_mem[waddr] <= wdata;
      end
      rdata_ff  <= list_mem[raddr];
      rvalid_ff <= valid_ff[raddr] && !clear;
      ridx_ff   <= raddr;
   end

   // The shift never writes at or in front of the destination slot.
   a_move_above_dest: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MOVE |-> pos_ff > e_ff)
      else $error("shift position reached the destination slot");

   // The destination always lies in front of the found position.
   a_quot_below_pos: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV && div_stat.done |-> div_quot < s_ff)
      else $error("divider quotient not below the found position");

   // The divider stays busy until it reports its quotient.
   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV && !div_stat.done |-> div_stat.busy)
      else $error("divider idle while the sequencer waits for it");

   // An accepted request closes the request channel on the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_ready)
      else $error("request accepted while a transaction is in progress");

   // A finished result is held back while the previous response is stalled.
   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && rsp_valid_ff && !rsp_ready |=> state_ff == S_DONE)
      else $error("result left the sequencer while the response was stalled");

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the partial move-to-front coder.
// Needs pmtf_pkg, pmtf_div and partial_move_to_front_coder_top; it keeps its own copy of the list
// and predicts every response from the accepted requests.
`timescale 1ns / 100ps

module tb_top import pmtf_pkg::*; ();

   // Operation codes carried by req_op.
   typedef enum logic {
      OP_ENCODE = 1'b0,
      OP_DECODE = 1'b1
   } op_type;

   // Byte address of the move divisor register on the configuration port.
   localparam logic [2:0] CSR_MOVE_DIVISOR = 3'd0;

   localparam int ALPHABET     = 128;
   localparam int IDLE_PCT     = 20;
   localparam int RAND_PHASES  = 10;
   localparam int PHASE_ITEMS  = 163;
   // This pause outlasts the longest request (search and shift over the
   // whole list), so no move is still running when it ends.
   localparam int SETTLE       = 2 * ALPHABET + 40;
   localparam int HOLD_AT      = 500;
   localparam int HOLD_CYCLES  = 400;
   localparam int QUIET_FROM   = 900;
   localparam int QUIET_TO     = 1150;
   localparam int CYCLE_LIMIT  = 2_000_000;

   // One row of the directed table. When set_div is high the divisor is
   // rewritten (with the block idle) before the transaction is sent. When
   // has_want is high the typed-in value is the expected response.
   typedef struct {
      logic               set_div;
      logic [7:0]         div;
      op_type             op;
      logic [VALUE_W-1:0] value;
      logic               restart;
      logic               has_want;
      logic [VALUE_W-1:0] want;
   } stim_row_type;

   // A response that is still owed by the block.
   typedef struct {
      logic [VALUE_W-1:0] out_value;
      int                 item;
   } pending_type;

   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               req_valid     = 1'b0;
   logic               req_ready;
   logic               req_op        = 1'b0;
   logic [VALUE_W-1:0] req_in_value  = '0;
   logic               req_restart   = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready     = 1'b0;
   logic [VALUE_W-1:0] rsp_out_value;
   logic               psel          = 1'b0;
   logic               penable       = 1'b0;
   logic               pwrite        = 1'b0;
   logic [2:0]         paddr         = '0;
   logic [31:0]        pwdata        = '0;
   logic [31:0]        prdata;
   logic               pready;

   // The testbench's own copy of the symbol list and of the divisor.
   logic [VALUE_W-1:0] mtf_list [ALPHABET];
   logic [7:0]         move_div;

   pending_type        pending_out_values[$];
   int                 error_count    = 0;
   int                 accepted_count = 0;
   int                 cycle_count    = 0;
   // While quiet is high neither side inserts random idle cycles.
   logic               quiet          = 1'b0;

   // Directed part: extremes of the fields, both operations, restart, and
   // the divisor corner cases (zero, one, the largest value, a divisor
   // larger than any position).
   stim_row_type directed_rows [24] = '{
      // Reset divisor of 2. The front entry never moves anything.
      '{1'b0, 8'd0,   OP_ENCODE, 7'd0,   1'b0, 1'b1, 7'd0},
      // The last symbol is found at 127 and moves to 63.
      '{1'b0, 8'd0,   OP_ENCODE, 7'd127, 1'b0, 1'b1, 7'd127},
      '{1'b0, 8'd0,   OP_DECODE, 7'd63,  1'b0, 1'b0, 7'd0},
      '{1'b0, 8'd0,   OP_DECODE, 7'd0,   1'b0, 1'b1, 7'd0},
      // Restart brings back identity order before the lookup.
      '{1'b0, 8'd0,   OP_ENCODE, 7'd127, 1'b1, 1'b1, 7'd127},
      '{1'b0, 8'd0,   OP_DECODE, 7'd127, 1'b1, 1'b1, 7'd127},
      '{1'b0, 8'd0,   OP_ENCODE, 7'd1,   1'b1, 1'b1, 7'd1},
      '{1'b0, 8'd0,   OP_ENCODE, 7'd0,   1'b0, 1'b0, 7'd0},
      '{1'b0, 8'd0,   OP_DECODE, 7'd85,  1'b0, 1'b0, 7'd0},
      '{1'b0, 8'd0,   OP_ENCODE, 7'd42,  1'b0, 1'b0, 7'd0},
      // A divisor of one leaves the list alone.
      '{1'b1, 8'd1,   OP_ENCODE, 7'd127, 1'b1, 1'b1, 7'd127},
      '{1'b0, 8'd0,   OP_ENCODE, 7'd127, 1'b0, 1'b1, 7'd127},
      '{1'b0, 8'd0,   OP_DECODE, 7'd64,  1'b0, 1'b1, 7'd64},
      // A divisor of zero behaves like one.
      '{1'b1, 8'd0,   OP_ENCODE, 7'd127, 1'b1, 1'b1, 7'd127},
      '{1'b0, 8'd0,   OP_ENCODE, 7'd127, 1'b0, 1'b1, 7'd127},
      // The largest divisor sends every found entry to the front.
      '{1'b1, 8'd255, OP_ENCODE, 7'd127, 1'b1, 1'b1, 7'd127},
      '{1'b0, 8'd0,   OP_ENCODE, 7'd127, 1'b0, 1'b1, 7'd0},
      '{1'b0, 8'd0,   OP_DECODE, 7'd0,   1'b0, 1'b1, 7'd127},
      '{1'b0, 8'd0,   OP_DECODE, 7'd1,   1'b0, 1'b1, 7'd0},
      // A divisor equal to the alphabet size also moves to the front.
      '{1'b1, 8'd128, OP_ENCODE, 7'd127, 1'b1, 1'b1, 7'd127},
      '{1'b0, 8'd0,   OP_ENCODE, 7'd126, 1'b0, 1'b0, 7'd0},
      '{1'b1, 8'd3,   OP_DECODE, 7'd127, 1'b1, 1'b1, 7'd127},
      '{1'b0, 8'd0,   OP_ENCODE, 7'd127, 1'b0, 1'b0, 7'd0},
      '{1'b0, 8'd0,   OP_DECODE, 7'd42,  1'b0, 1'b0, 7'd0}
   };

   partial_move_to_front_coder_top DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_in_value (req_in_value),
      .req_restart  (req_restart),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_value(rsp_out_value),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready)
   );

   // The clock runs with an 8 ns period.
   initial begin
      forever #4 clock = ~clock;
   end

   // Watchdog. A lost response or a stuck handshake ends the run here.
   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
         end
      end
   end

   // Prints one line per mismatch and counts it.
   task automatic report_mismatch(input string what, input int item,
                                  input int got, input int want);
      error_count++;
      $display("mismatch: %s item %0d got %0d expected %0d", what, item, got, want);
   endtask

   // Puts the model list back into identity order.
   function automatic void restart_list();
      for (int i = 0; i < ALPHABET; i++) begin
         mtf_list[i] = VALUE_W'(i);
      end
   endfunction

   // Works out the response of one request and applies its move to the
   // model list. Encode searches the symbol and returns its position;
   // decode returns the symbol at the given position. The entry found at
   // position pos then moves to pos / divisor and the entries in between
   // shift one place toward the end. Divisors of zero and one, and a hit at
   // the front, leave the list as it is.
   function automatic logic [VALUE_W-1:0] mtf_code(input op_type op,
                                                   input logic [VALUE_W-1:0] value,
                                                   input logic restart);
      int                 pos;
      int                 dest;
      logic [VALUE_W-1:0] sym;
      logic [VALUE_W-1:0] result;
      if (restart) begin
         restart_list();
      end
      pos = 0;
      if (op == OP_ENCODE) begin
         // Every 7-bit symbol is in a 128-entry list, so the search always hits.
         for (int p = ALPHABET - 1; p >= 0; p--) begin
            if (mtf_list[p] == value) begin
               pos = p;
            end
         end
         result = VALUE_W'(pos);
      end else begin
         pos    = int'(value);
         result = mtf_list[pos];
      end
      if (move_div > 8'd1 && pos > 0) begin
         dest = pos / int'(move_div);
         sym  = mtf_list[pos];
         for (int p = pos; p > dest; p--) begin
            mtf_list[p] = mtf_list[p - 1];
         end
         mtf_list[dest] = sym;
      end
      return result;
   endfunction

   // Offers one request transaction and waits until it is accepted. The
   // prediction is made at the accepting edge, so the model sees requests in
   // exactly the order the block does. Valid is left high on return; the
   // caller either sends the next request in the same step or lowers it.
   task automatic send_request(input op_type op, input logic [VALUE_W-1:0] value,
                               input logic restart, input logic has_want,
                               input logic [VALUE_W-1:0] want);
      pending_type        owed;
      logic [VALUE_W-1:0] predicted;
      if (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_in_value <= value;
      req_restart  <= restart;
      do @(posedge clock); while (!req_ready);
      predicted      = mtf_code(op, value, restart);
      owed.out_value = has_want ? want : predicted;
      owed.item      = accepted_count;
      pending_out_values = {pending_out_values, owed};
      accepted_count++;
   endtask

   // Stops offering requests and waits until every owed response has come.
   // At least one clock passes, so valid is never lowered and raised again
   // in the same step.
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_out_values.size() != 0);
   endtask

   // Writes the move divisor while the block is idle and reads it back. The
   // upper data bits are random; only the low byte belongs to the register.
   task automatic write_divisor(input logic [7:0] div);
      drain_responses();
      repeat (SETTLE) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_MOVE_DIVISOR;
      pwdata  <= {24'($urandom()), div};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      move_div = div;
      // Read back through the same port.
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[7:0] !== div) begin
         report_mismatch("move_divisor readback", accepted_count, int'(prdata[7:0]),
                         int'(div));
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Response monitor. Every accepted response is checked against the oldest
   // owed value; a response that nobody asked for is an error too.
   always @(posedge clock) begin
      pending_type owed;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_out_values.size() == 0) begin
            report_mismatch("unexpected response", -1, int'(rsp_out_value), 0);
         end else begin
            owed = pending_out_values.pop_front();
            if (rsp_out_value !== owed.out_value) begin
               report_mismatch("out_value", owed.item, int'(rsp_out_value),
                               int'(owed.out_value));
            end
         end
      end
   end

   // Response side back-pressure. Ready drops in about one cycle out of five,
   // stays high through the quiet window, and once in the run is held low
   // for a long stretch so that the output register fills and the block
   // stops taking requests while the sender keeps offering.
   always @(posedge clock) begin
      static int   hold_left = 0;
      static logic hold_done = 1'b0;
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && accepted_count >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Stimulus: reset, the directed table, then random phases each under its
   // own divisor setting, and finally the drain and the verdict.
   initial begin
      logic [7:0]         phase_divs [RAND_PHASES];
      logic [VALUE_W-1:0] value;
      logic [VALUE_W-1:0] last_value;
      op_type             op;
      logic               restart;
      int                 roll;

      restart_list();
      move_div   = DIVISOR_RESET;
      last_value = '0;
      // Divisor settings of the random part, extremes included.
      phase_divs = '{8'd2, 8'd1, 8'd255, 8'($urandom_range(1, 255)), 8'd3,
                     8'd0, 8'($urandom_range(1, 255)), 8'd128, 8'd2,
                     8'($urandom_range(1, 255))};

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].set_div) begin
            write_divisor(directed_rows[r].div);
         end
         send_request(directed_rows[r].op, directed_rows[r].value,
                      directed_rows[r].restart, directed_rows[r].has_want,
                      directed_rows[r].want);
      end

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         write_divisor(phase_divs[ph]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Once in the run the sender waits for every owed response.
            if (ph == 3 && n == 80) begin
               drain_responses();
            end
            quiet = (accepted_count >= QUIET_FROM && accepted_count < QUIET_TO);
            // Values lean toward small positions and repeats, which keep
            // hitting entries that have just moved, while the uniform share
            // reaches the whole list.
            roll = $urandom_range(99);
            if (roll < 50) begin
               value = VALUE_W'($urandom_range(127));
            end else if (roll < 80) begin
               value = VALUE_W'($urandom_range(7));
            end else begin
               value = last_value;
            end
            op         = op_type'($urandom_range(1));
            restart    = ($urandom_range(99) < 3);
            last_value = value;
            send_request(op, value, restart, 1'b0, '0);
         end
      end
      quiet = 1'b0;

      drain_responses();
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0 && pending_out_values.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
